[sv/ppc_pkg.sv]
`default_nettype none

package ppc_pkg;

  localparam int SpriteSlotsDefault = 8;
  localparam int PaletteDepth = 32;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW = 1;

  typedef enum logic [1:0] {
    ACT_RENDER      = 2'd0,
    ACT_LOAD_SPRITE = 2'd1,
    ACT_WRITE_PAL   = 2'd2,
    ACT_SET_COUNT   = 2'd3
  } action_t;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_BG_ENABLE              = 3'd0,
    CFG_SPR_ENABLE             = 3'd1,
    CFG_LEFT_COLUMN_BACKGROUND = 3'd2,
    CFG_LEFT_COLUMN_SPRITES    = 3'd3,
    CFG_GRAYSCALE              = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_LOOK
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  screen_x;
    logic [2:0]  fine_x;
    logic [15:0] bg_pattern_low_bits;
    logic [15:0] bg_pattern_high_bits;
    logic [15:0] bg_palette_low_bits;
    logic [15:0] bg_palette_high_bits;
    logic [14:0] video_address;
    logic [4:0]  index;
    logic [32:0] sprite_entry;
    logic [5:0]  palette_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0] colour;
    logic       background_opaque;
    logic       sprite_zero_hit;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic calc;
    logic load_out;
  } cmd_t;

  function automatic logic [4:0] pal_mirror(input logic [4:0] a);
    logic [4:0] m;
    m = a;
    if (a[4] && (a[1:0] == 2'b00)) begin
      m = {1'b0, a[3:0]};
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[sv/ppc_if.sv]
`default_nettype none

interface ppc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  screen_x;
  logic [2:0]  fine_x;
  logic [15:0] bg_pattern_low_bits;
  logic [15:0] bg_pattern_high_bits;
  logic [15:0] bg_palette_low_bits;
  logic [15:0] bg_palette_high_bits;
  logic [14:0] video_address;
  logic [4:0]  index;
  logic [32:0] sprite_entry;
  logic [5:0]  palette_value;

  modport source (
    output valid, action, screen_x, fine_x, bg_pattern_low_bits, bg_pattern_high_bits,
           bg_palette_low_bits, bg_palette_high_bits, video_address, index,
           sprite_entry, palette_value,
    input  ready
  );

  modport sink (
    input  valid, action, screen_x, fine_x, bg_pattern_low_bits, bg_pattern_high_bits,
           bg_palette_low_bits, bg_palette_high_bits, video_address, index,
           sprite_entry, palette_value,
    output ready
  );
endinterface

interface ppc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] colour;
  logic       background_opaque;
  logic       sprite_zero_hit;

  modport source (
    output valid, colour, background_opaque, sprite_zero_hit,
    input  ready
  );

  modport sink (
    input  valid, colour, background_opaque, sprite_zero_hit,
    output ready
  );
endinterface

`default_nettype wire

[sv/ppc_ctrl.sv]
`default_nettype none

module ppc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_action,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ppc_pkg::cmd_t      cmd
);

  ppc_pkg::state_t state;
  ppc_pkg::state_t state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ppc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.calc     = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      ppc_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && (in_action == ppc_pkg::ACT_RENDER)) begin
          state_next = ppc_pkg::ST_CALC;
        end
      end
      ppc_pkg::ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ppc_pkg::ST_LOOK;
      end
      ppc_pkg::ST_LOOK: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ppc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ppc_pkg::ST_IDLE;
      end
    endcase
    out_valid_next = cmd.load_out || (out_valid && !out_ready);
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  a_render_starts: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && (in_action == ppc_pkg::ACT_RENDER)) |=> cmd.calc)
    else $error("accepted render beat did not start composition");

  a_busy_after_calc: assert property (@(posedge clk) disable iff (rst)
    cmd.calc |=> (!in_ready && !cmd.calc))
    else $error("input taken while a pixel is in flight");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

[sv/ppc_datapath.sv]
`default_nettype none

module ppc_datapath #(
  parameter int SPRITE_SLOTS = ppc_pkg::SpriteSlotsDefault
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ppc_pkg::cmd_t                  cmd,
  input  wire ppc_pkg::in_item_t              in_item,
  input  wire logic                           cfg_write,
  input  wire logic [ppc_pkg::CfgIndexW-1:0]  cfg_index,
  input  wire logic [ppc_pkg::CfgDataW-1:0]   cfg_data,
  output ppc_pkg::out_item_t                  out_item
);

  localparam int CntW = $clog2(SPRITE_SLOTS + 1);

  logic bg_enable;
  logic spr_enable;
  logic left_column_background;
  logic left_column_sprites;
  logic grayscale;

  logic [32:0]     slots [SPRITE_SLOTS];
  logic [CntW-1:0] sprite_count;
  logic [5:0]      palette [ppc_pkg::PaletteDepth];

  logic [7:0]  sx;
  logic [2:0]  fx;
  logic [15:0] pl;
  logic [15:0] ph;
  logic [15:0] al;
  logic [15:0] ah;
  logic [14:0] vaddr;

  logic [4:0] pidx;
  logic       bg_opaque;
  logic       hit;

  logic [SPRITE_SLOTS-1:0] lane_opaque;
  logic [1:0]              lane_px [SPRITE_SLOTS];

  logic [3:0] pos;
  logic       bg_en;
  logic       sp_en;
  logic [1:0] bg;
  logic [1:0] bg_pal;
  logic       win_found;
  logic [1:0] win_px;
  logic [1:0] win_pal;
  logic       win_behind;
  logic       win_zero;
  logic [4:0] pidx_next;
  logic       hit_next;
  logic [5:0] colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_enable              <= 1'b0;
      spr_enable             <= 1'b0;
      left_column_background <= 1'b0;
      left_column_sprites    <= 1'b0;
      grayscale              <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        ppc_pkg::CFG_BG_ENABLE:              bg_enable              <= cfg_data[0];
        ppc_pkg::CFG_SPR_ENABLE:             spr_enable             <= cfg_data[0];
        ppc_pkg::CFG_LEFT_COLUMN_BACKGROUND: left_column_background <= cfg_data[0];
        ppc_pkg::CFG_LEFT_COLUMN_SPRITES:    left_column_sprites    <= cfg_data[0];
        ppc_pkg::CFG_GRAYSCALE:              grayscale              <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_count <= '0;
    end else if (cmd.accept && (in_item.action == ppc_pkg::ACT_SET_COUNT)) begin
      if ({1'b0, in_item.index} > 6'(SPRITE_SLOTS)) begin
        sprite_count <= CntW'(SPRITE_SLOTS);
      end else begin
        sprite_count <= CntW'(in_item.index);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ppc_pkg::PaletteDepth; i++) begin
        palette[i] <= '0;
      end
    end else if (cmd.accept && (in_item.action == ppc_pkg::ACT_WRITE_PAL)) begin
      palette[ppc_pkg::pal_mirror(in_item.index)] <= in_item.palette_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sx    <= in_item.screen_x;
      fx    <= in_item.fine_x;
      pl    <= in_item.bg_pattern_low_bits;
      ph    <= in_item.bg_pattern_high_bits;
      al    <= in_item.bg_palette_low_bits;
      ah    <= in_item.bg_palette_high_bits;
      vaddr <= in_item.video_address;
    end
  end

  for (genvar g = 0; g < SPRITE_SLOTS; g++) begin : g_lane
    logic [8:0] diff;
    logic [2:0] b;

    always_ff @(posedge clk) begin
      if (cmd.accept && (in_item.action == ppc_pkg::ACT_LOAD_SPRITE) &&
          (in_item.index == 5'(g))) begin
        slots[g] <= in_item.sprite_entry;
      end
    end

    always_comb begin
      diff = {1'b0, sx} - {1'b0, slots[g][7:0]};
      b    = slots[g][14] ? diff[2:0] : ~diff[2:0];
      lane_px[g] = {slots[g][24 + b], slots[g][16 + b]};
      lane_opaque[g] = (sprite_count > CntW'(g)) && !diff[8] && (diff[7:3] == 5'd0) &&
                       (lane_px[g] != 2'b00);
    end
  end

  always_comb begin
    pos    = {1'b1, ~fx};
    bg_en  = bg_enable && ((sx[7:3] != 5'd0) || left_column_background);
    sp_en  = spr_enable && ((sx[7:3] != 5'd0) || left_column_sprites);
    bg     = bg_en ? {ph[pos], pl[pos]} : 2'b00;
    bg_pal = bg_en ? {ah[pos], al[pos]} : 2'b00;

    win_found  = 1'b0;
    win_px     = 2'b00;
    win_pal    = 2'b00;
    win_behind = 1'b0;
    win_zero   = 1'b0;
    for (int i = SPRITE_SLOTS - 1; i >= 0; i--) begin
      if (lane_opaque[i]) begin
        win_found  = 1'b1;
        win_px     = lane_px[i];
        win_pal    = slots[i][9:8];
        win_behind = slots[i][13];
        win_zero   = slots[i][32];
      end
    end

    pidx_next = (bg != 2'b00) ? {1'b0, bg_pal, bg} : 5'd0;
    hit_next  = 1'b0;
    if (sp_en && win_found) begin
      hit_next = win_zero && (bg != 2'b00) && (sx != 8'hFF);
      if ((bg == 2'b00) || !win_behind) begin
        pidx_next = {1'b1, win_pal, win_px};
      end
    end
    if (!bg_enable && !spr_enable && (vaddr[13:8] == 6'h3F)) begin
      pidx_next = vaddr[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      pidx      <= pidx_next;
      bg_opaque <= (bg != 2'b00);
      hit       <= hit_next;
    end
  end

  always_comb begin
    colour = palette[ppc_pkg::pal_mirror(pidx)];
    if (grayscale) begin
      colour = colour & 6'h30;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item.colour            <= colour;
      out_item.background_opaque <= bg_opaque;
      out_item.sprite_zero_hit   <= hit;
    end
  end

endmodule

`default_nettype wire

[sv/pixel_priority_compositor.sv]
// Flow: a render beat is accepted and its fields registered, composed into a registered
// palette index, then looked up in the palette and registered once the output is free.
// The three-state sequencer takes no new beat until the render result is loaded, which
// waits while an earlier result is not taken; sprite, palette and count writes leave it idle.
// Reset: synchronous, active high; clears configuration, sprite count, palette and
// handshake state. Sprite slots are not cleared and hold nothing until loaded.
`default_nettype none

module pixel_priority_compositor #(
  parameter int SPRITE_SLOTS = ppc_pkg::SpriteSlotsDefault
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  ppc_in_if.sink                              pixel_in,
  ppc_out_if.source                           pixel_out,
  input  wire logic                           cfg_write,
  input  wire logic [ppc_pkg::CfgIndexW-1:0]  cfg_index,
  input  wire logic [ppc_pkg::CfgDataW-1:0]   cfg_data
);

  ppc_pkg::cmd_t      cmd;
  ppc_pkg::in_item_t  in_item;
  ppc_pkg::out_item_t out_item;
  logic               in_ready;
  logic               out_valid;

  assign in_item.action               = pixel_in.action;
  assign in_item.screen_x             = pixel_in.screen_x;
  assign in_item.fine_x               = pixel_in.fine_x;
  assign in_item.bg_pattern_low_bits  = pixel_in.bg_pattern_low_bits;
  assign in_item.bg_pattern_high_bits = pixel_in.bg_pattern_high_bits;
  assign in_item.bg_palette_low_bits  = pixel_in.bg_palette_low_bits;
  assign in_item.bg_palette_high_bits = pixel_in.bg_palette_high_bits;
  assign in_item.video_address        = pixel_in.video_address;
  assign in_item.index                = pixel_in.index;
  assign in_item.sprite_entry         = pixel_in.sprite_entry;
  assign in_item.palette_value        = pixel_in.palette_value;

  assign pixel_in.ready              = in_ready;
  assign pixel_out.valid             = out_valid;
  assign pixel_out.colour            = out_item.colour;
  assign pixel_out.background_opaque = out_item.background_opaque;
  assign pixel_out.sprite_zero_hit   = out_item.sprite_zero_hit;

  ppc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel_in.valid),
    .in_action (pixel_in.action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (pixel_out.ready),
    .cmd       (cmd)
  );

  ppc_datapath #(
    .SPRITE_SLOTS (SPRITE_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

[tb/sv/pixel_priority_compositor_scoreboard.sv]
module pixel_priority_compositor_scoreboard #(
  parameter int SLOTS = ppc_pkg::SpriteSlotsDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  ppc_in_if                                  pixel_in,
  ppc_out_if                                 pixel_out,
  input  wire logic                          cfg_write,
  input  wire logic [ppc_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [ppc_pkg::CfgDataW-1:0]  cfg_data,
  output int                                 fail_count,
  output int                                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic               show_bg;
  logic               show_spr;
  logic               left_bg;
  logic               left_spr;
  logic               gray;
  logic [32:0]        slots [SLOTS];
  int                 sprite_count;
  logic [5:0]         palette [ppc_pkg::PaletteDepth];
  ppc_pkg::out_item_t expected_pixels [$];
  ppc_pkg::in_item_t  beat;
  ppc_pkg::out_item_t seen;
  ppc_pkg::out_item_t want;

  function automatic logic [4:0] fold_palette_addr(input logic [4:0] a);
    return ((a & 5'h13) == 5'h10) ? a - 5'h10 : a;
  endfunction

  function automatic ppc_pkg::out_item_t compose_pixel(input ppc_pkg::in_item_t b);
    int                 sx;
    int                 pos;
    int                 bg;
    int                 pal;
    int                 pidx;
    int                 xpos;
    int                 col;
    int                 bsel;
    int                 px;
    logic [32:0]        s;
    logic [7:0]         attr;
    logic [7:0]         p0;
    logic [7:0]         p1;
    logic               hit;
    logic               done;
    logic [5:0]         c;
    ppc_pkg::out_item_t r;
    sx = b.screen_x;
    bg = 0;
    pal = 0;
    hit = 1'b0;
    done = 1'b0;
    if (show_bg && (sx >= 8 || left_bg)) begin
      pos = 15 - b.fine_x;
      bg = {b.bg_pattern_high_bits[pos], b.bg_pattern_low_bits[pos]};
      pal = {b.bg_palette_high_bits[pos], b.bg_palette_low_bits[pos]};
    end
    pidx = (bg != 0) ? pal * 4 + bg : 0;
    if (show_spr && (sx >= 8 || left_spr)) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!done && i < sprite_count) begin
          s = slots[i];
          xpos = s[7:0];
          attr = s[15:8];
          p0 = s[23:16];
          p1 = s[31:24];
          if (sx >= xpos && sx - xpos < 8) begin
            col = sx - xpos;
            bsel = attr[6] ? col : 7 - col;
            px = {p1[bsel], p0[bsel]};
            if (px != 0) begin
              if (s[32] && bg != 0 && sx != 255) hit = 1'b1;
              if (bg == 0 || !attr[5]) pidx = 'h10 + attr[1:0] * 4 + px;
              done = 1'b1;
            end
          end
        end
      end
    end
    if (!show_bg && !show_spr && b.video_address[13:8] == 6'h3F) pidx = b.video_address[4:0];
    c = palette[fold_palette_addr(5'(pidx))];
    if (gray) c = c & 6'h30;
    r.colour = c;
    r.background_opaque = (bg != 0);
    r.sprite_zero_hit = hit;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      show_bg = 1'b0;
      show_spr = 1'b0;
      left_bg = 1'b0;
      left_spr = 1'b0;
      gray = 1'b0;
      sprite_count = 0;
      for (int i = 0; i < ppc_pkg::PaletteDepth; i++) palette[i] = '0;
      expected_pixels.delete();
      fail_count = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          ppc_pkg::CFG_BG_ENABLE:              show_bg = cfg_data[0];
          ppc_pkg::CFG_SPR_ENABLE:             show_spr = cfg_data[0];
          ppc_pkg::CFG_LEFT_COLUMN_BACKGROUND: left_bg = cfg_data[0];
          ppc_pkg::CFG_LEFT_COLUMN_SPRITES:    left_spr = cfg_data[0];
          ppc_pkg::CFG_GRAYSCALE:              gray = cfg_data[0];
          default: ;
        endcase
      end
      if (pixel_out.valid && pixel_out.ready) begin
        seen.colour = pixel_out.colour;
        seen.background_opaque = pixel_out.background_opaque;
        seen.sprite_zero_hit = pixel_out.sprite_zero_hit;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel beat: expected none, got colour %0h", $time,
                   seen.colour);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (seen.colour !== want.colour) begin
            $display("%0t: colour expected %0h got %0h", $time, want.colour, seen.colour);
            fail_count++;
          end
          if (seen.background_opaque !== want.background_opaque) begin
            $display("%0t: background_opaque expected %0b got %0b", $time,
                     want.background_opaque, seen.background_opaque);
            fail_count++;
          end
          if (seen.sprite_zero_hit !== want.sprite_zero_hit) begin
            $display("%0t: sprite_zero_hit expected %0b got %0b", $time,
                     want.sprite_zero_hit, seen.sprite_zero_hit);
            fail_count++;
          end
        end
      end
      if (pixel_in.valid && pixel_in.ready) begin
        beat.action = pixel_in.action;
        beat.screen_x = pixel_in.screen_x;
        beat.fine_x = pixel_in.fine_x;
        beat.bg_pattern_low_bits = pixel_in.bg_pattern_low_bits;
        beat.bg_pattern_high_bits = pixel_in.bg_pattern_high_bits;
        beat.bg_palette_low_bits = pixel_in.bg_palette_low_bits;
        beat.bg_palette_high_bits = pixel_in.bg_palette_high_bits;
        beat.video_address = pixel_in.video_address;
        beat.index = pixel_in.index;
        beat.sprite_entry = pixel_in.sprite_entry;
        beat.palette_value = pixel_in.palette_value;
        case (beat.action)
          ppc_pkg::ACT_RENDER:
            expected_pixels.push_back(compose_pixel(beat));
          ppc_pkg::ACT_LOAD_SPRITE:
            if (beat.index < SLOTS) slots[beat.index] = beat.sprite_entry;
          ppc_pkg::ACT_WRITE_PAL:
            palette[fold_palette_addr(beat.index)] = beat.palette_value;
          ppc_pkg::ACT_SET_COUNT:
            sprite_count = (beat.index > SLOTS) ? SLOTS : beat.index;
          default: ;
        endcase
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

[tb/sv/pixel_priority_compositor_tb.sv]
module pixel_priority_compositor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = ppc_pkg::SpriteSlotsDefault;
  localparam int CycleLimit = 600000;
  localparam int SettleCycles = 8;
  localparam int Phases = 12;
  localparam int BeatsPerPhase = 150;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [ppc_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [ppc_pkg::CfgDataW-1:0]  cfg_data = '0;
  logic                          sink_ready = 1'b0;
  int                            fail_count;
  int                            outstanding;
  int                            cycles = 0;
  int                            hold = 0;
  int                            line_x = 0;
  bit                            send_idle = 1'b0;
  bit                            recv_idle = 1'b0;
  logic [7:0]                    slot_x [Slots];

  ppc_in_if  pixel_in ();
  ppc_out_if pixel_out ();

  assign pixel_out.ready = sink_ready;

  pixel_priority_compositor uut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pixel_in),
    .pixel_out (pixel_out),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pixel_priority_compositor_scoreboard #(.SLOTS(Slots)) board (
    .clk         (clk),
    .rst         (rst),
    .pixel_in    (pixel_in),
    .pixel_out   (pixel_out),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("pixel_priority_compositor_tb: FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (!recv_idle) begin
      sink_ready <= 1'b1;
      hold = 0;
    end else if (hold != 0) begin
      sink_ready <= 1'b0;
      hold = hold - 1;
    end else begin
      sink_ready <= 1'b1;
      hold = pick_gap();
    end
  end

  function automatic logic [32:0] sprite_word(input logic z, input logic [7:0] p1,
                                              input logic [7:0] p0, input logic [7:0] attr,
                                              input logic [7:0] x);
    return {z, p1, p0, attr, x};
  endfunction

  function automatic ppc_pkg::in_item_t render_beat(input logic [7:0] sx,
                                                    input logic [2:0] fx,
                                                    input logic [15:0] pl,
                                                    input logic [15:0] ph,
                                                    input logic [15:0] al,
                                                    input logic [15:0] ah,
                                                    input logic [14:0] vaddr);
    ppc_pkg::in_item_t b;
    b = '0;
    b.action = ppc_pkg::ACT_RENDER;
    b.screen_x = sx;
    b.fine_x = fx;
    b.bg_pattern_low_bits = pl;
    b.bg_pattern_high_bits = ph;
    b.bg_palette_low_bits = al;
    b.bg_palette_high_bits = ah;
    b.video_address = vaddr;
    return b;
  endfunction

  function automatic ppc_pkg::in_item_t control_beat(input ppc_pkg::action_t a,
                                                     input logic [4:0] idx,
                                                     input logic [32:0] entry,
                                                     input logic [5:0] val);
    ppc_pkg::in_item_t b;
    b = '0;
    b.action = a;
    b.index = idx;
    b.sprite_entry = entry;
    b.palette_value = val;
    return b;
  endfunction

  function automatic logic [15:0] shift_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic ppc_pkg::in_item_t next_random_beat();
    ppc_pkg::in_item_t b;
    int                r;
    int                k;
    r = $urandom_range(0, 99);
    b.screen_x = 8'($urandom);
    b.fine_x = 3'($urandom);
    b.bg_pattern_low_bits = shift_word();
    b.bg_pattern_high_bits = shift_word();
    b.bg_palette_low_bits = shift_word();
    b.bg_palette_high_bits = shift_word();
    b.video_address = 15'($urandom);
    b.index = 5'($urandom);
    b.sprite_entry = {1'($urandom), 32'($urandom)};
    b.palette_value = 6'($urandom);
    if (r < 62) begin
      b.action = ppc_pkg::ACT_RENDER;
      k = $urandom_range(0, 9);
      if (k < 4) begin
        b.screen_x = slot_x[$urandom_range(0, Slots - 1)] + 8'($urandom_range(0, 7));
      end else if (k < 7) begin
        b.screen_x = 8'(line_x);
        line_x = (line_x + 1) % 256;
      end
      if ($urandom_range(0, 3) == 0) begin
        b.video_address[13:8] = 6'h3F;
      end
    end else if (r < 75) begin
      b.action = ppc_pkg::ACT_LOAD_SPRITE;
      b.index = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, Slots - 1)) :
                                                5'($urandom_range(Slots, 31));
      k = $urandom_range(0, 9);
      if (k == 0) begin
        b.sprite_entry[7:0] = 8'($urandom_range(248, 255));
      end else if (k == 1) begin
        b.sprite_entry[7:0] = 8'($urandom_range(0, 7));
      end
    end else if (r < 88) begin
      b.action = ppc_pkg::ACT_WRITE_PAL;
    end else begin
      b.action = ppc_pkg::ACT_SET_COUNT;
      if ($urandom_range(0, 9) < 3) b.index = 5'(Slots);
    end
    return b;
  endfunction

  task automatic put_fields(input ppc_pkg::in_item_t b);
    pixel_in.action <= b.action;
    pixel_in.screen_x <= b.screen_x;
    pixel_in.fine_x <= b.fine_x;
    pixel_in.bg_pattern_low_bits <= b.bg_pattern_low_bits;
    pixel_in.bg_pattern_high_bits <= b.bg_pattern_high_bits;
    pixel_in.bg_palette_low_bits <= b.bg_palette_low_bits;
    pixel_in.bg_palette_high_bits <= b.bg_palette_high_bits;
    pixel_in.video_address <= b.video_address;
    pixel_in.index <= b.index;
    pixel_in.sprite_entry <= b.sprite_entry;
    pixel_in.palette_value <= b.palette_value;
  endtask

  task automatic send_beat(input ppc_pkg::in_item_t b);
    int g;
    g = send_idle ? pick_gap() : 0;
    repeat (g) begin
      @(negedge clk);
      pixel_in.valid <= 1'b0;
    end
    @(negedge clk);
    put_fields(b);
    pixel_in.valid <= 1'b1;
    do @(posedge clk); while (pixel_in.ready !== 1'b1);
    if (b.action == ppc_pkg::ACT_LOAD_SPRITE && b.index < Slots) begin
      slot_x[b.index] = b.sprite_entry[7:0];
    end
  endtask

  task automatic settle();
    @(negedge clk);
    pixel_in.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input ppc_pkg::cfg_reg_t r, input bit v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_config(input bit bg, input bit spr, input bit lbg, input bit lspr,
                            input bit gray);
    write_reg(ppc_pkg::CFG_BG_ENABLE, bg);
    write_reg(ppc_pkg::CFG_SPR_ENABLE, spr);
    write_reg(ppc_pkg::CFG_LEFT_COLUMN_BACKGROUND, lbg);
    write_reg(ppc_pkg::CFG_LEFT_COLUMN_SPRITES, lspr);
    write_reg(ppc_pkg::CFG_GRAYSCALE, gray);
  endtask

  initial begin
    pixel_in.valid <= 1'b0;
    put_fields('0);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every slot is loaded before any sprite count is set, so no render reads an empty slot.
    send_beat(control_beat(ppc_pkg::ACT_LOAD_SPRITE, 5'd0,
                           sprite_word(1'b1, 8'hFF, 8'hFF, 8'h00, 8'd248), 6'd0));
    send_beat(control_beat(ppc_pkg::ACT_LOAD_SPRITE, 5'd1,
                           sprite_word(1'b0, 8'h00, 8'h01, 8'h41, 8'd0), 6'd0));
    send_beat(control_beat(ppc_pkg::ACT_LOAD_SPRITE, 5'd2,
                           sprite_word(1'b0, 8'hAA, 8'hFF, 8'h23, 8'd100), 6'd0));
    send_beat(control_beat(ppc_pkg::ACT_LOAD_SPRITE, 5'd3,
                           sprite_word(1'b1, 8'hFF, 8'hFF, 8'h02, 8'd100), 6'd0));
    send_beat(control_beat(ppc_pkg::ACT_LOAD_SPRITE, 5'd4,
                           sprite_word(1'b0, 8'h00, 8'h00, 8'h00, 8'd200), 6'd0));
    send_beat(control_beat(ppc_pkg::ACT_LOAD_SPRITE, 5'd5,
                           sprite_word(1'b0, 8'h80, 8'h00, 8'h01, 8'd200), 6'd0));
    send_beat(control_beat(ppc_pkg::ACT_LOAD_SPRITE, 5'd6,
                           sprite_word(1'b0, 8'h0F, 8'hF0, 8'h62, 8'd4), 6'd0));
    send_beat(control_beat(ppc_pkg::ACT_LOAD_SPRITE, 5'd7, 33'h1_FFFF_FFFF, 6'd0));
    send_beat(control_beat(ppc_pkg::ACT_LOAD_SPRITE, 5'd8, 33'h1_2345_6789, 6'd0));
    send_beat(control_beat(ppc_pkg::ACT_LOAD_SPRITE, 5'd31, 33'h0_0000_0000, 6'd0));
    send_beat(control_beat(ppc_pkg::ACT_WRITE_PAL, 5'h10, 33'd0, 6'h2A));
    send_beat(control_beat(ppc_pkg::ACT_WRITE_PAL, 5'h1F, 33'd0, 6'h3F));
    send_beat(control_beat(ppc_pkg::ACT_WRITE_PAL, 5'h05, 33'd0, 6'h15));
    send_beat(control_beat(ppc_pkg::ACT_WRITE_PAL, 5'h14, 33'd0, 6'h01));
    send_beat(control_beat(ppc_pkg::ACT_SET_COUNT, 5'd31, 33'd0, 6'd0));
    send_beat(render_beat(8'd0, 3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h3F1F));
    send_beat(render_beat(8'd0, 3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h7F10));
    send_beat(render_beat(8'd0, 3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h3E05));

    settle();
    set_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_beat(render_beat(8'd0, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h0000));
    send_beat(render_beat(8'd250, 3'd7, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 15'h0000));
    send_beat(render_beat(8'd255, 3'd3, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 15'h7FFF));
    send_beat(render_beat(8'd100, 3'd0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 15'h0000));
    send_beat(render_beat(8'd100, 3'd5, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 15'h0000));
    send_beat(render_beat(8'd200, 3'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h0000));

    settle();
    set_config(1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
    send_beat(render_beat(8'd7, 3'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h0000));
    send_beat(render_beat(8'd8, 3'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h0000));
    send_beat(control_beat(ppc_pkg::ACT_SET_COUNT, 5'd0, 33'd0, 6'd0));
    send_beat(render_beat(8'd250, 3'd4, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 15'h0000));

    for (int phase = 0; phase < Phases; phase++) begin
      settle();
      case (phase)
        0:       set_config(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        1:       set_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        2:       set_config(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        default: set_config($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                            1'($urandom), 1'($urandom), $urandom_range(0, 3) == 0);
      endcase
      send_idle = (phase == 2) ? 1'b0 : ($urandom_range(0, 2) != 0);
      recv_idle = (phase == 2) ? 1'b0 : ($urandom_range(0, 2) != 0);
      repeat (BeatsPerPhase) send_beat(next_random_beat());
    end

    settle();
    if (fail_count == 0) begin
      $display("pixel_priority_compositor_tb: PASS");
    end else begin
      $display("pixel_priority_compositor_tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
sv/ppc_pkg.sv
sv/ppc_if.sv
sv/ppc_ctrl.sv
sv/ppc_datapath.sv
sv/pixel_priority_compositor.sv
tb/sv/pixel_priority_compositor_scoreboard.sv
tb/sv/pixel_priority_compositor_tb.sv
